// ----- hdl/hcb_pkg.sv -----
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the huffman code builder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

  localparam int MAX_SYMBOLS = 64;
  localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
  localparam int WEIGHT_W    = 16;
  localparam int SUM_W       = 22;
  localparam int NODE_W      = 7;
  localparam int POS_W       = 7;
  localparam int ADDR_W      = 6;
  localparam int CODE_W      = 63;
  localparam int LEN_W       = 6;

  typedef struct packed {
    logic [SUM_W-1:0]  w;
    logic [NODE_W-1:0] node;
  } heap_entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_HP_START,
    OP_SD_LOADCUR,
    OP_SD_ISSUE,
    OP_SD_FINAL,
    OP_SD_CMP,
    OP_POP_READ,
    OP_POP_TAKE,
    OP_PAR_A,
    OP_PAR_B,
    OP_SU_ISSUE,
    OP_SU_FINAL,
    OP_SU_CMP,
    OP_WK_INIT
  } dp_op_t;

  typedef enum logic [1:0] {
    WK_NONE,
    WK_STEP,
    WK_EMIT,
    WK_NEXT
  } wk_op_t;

  typedef struct packed {
    dp_op_t op;
    wk_op_t wk;
    logic   second;
  } dp_cmd_t;

  typedef struct packed {
    logic kid_gt_end;
    logic sd_move;
    logic at_is_one;
    logic su_move;
    logic idx_zero;
    logic fill_gt1;
    logic walk_done;
    logic k_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/huffman_code_builder.sv -----
// ----------------------------------------------------------------------------
// huffman_code_builder
// Loads a batch of weights and returns one huffman code per weight.
// ----------------------------------------------------------------------------
// Weights load one beat per cycle (up to 64, extras dropped); the beat with
// last_weight set starts the build. The heap sits in a single memory with two
// read ports and one write port, so each sift level issues its reads in a test
// state and compares and writes back in a compare state. The code walk then
// reads one parent per S_WK_TEST/S_WK_STEP pair and waits in S_WK_OUT for
// out_ready. No input beat is taken from the last_weight beat until the final
// code beat is accepted.
`default_nettype none

module huffman_code_builder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [hcb_pkg::WEIGHT_W-1:0]  weight,
  input  wire logic                          last_weight,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [hcb_pkg::CODE_W-1:0]         code_bits,
  output logic [hcb_pkg::LEN_W-1:0]          code_length,
  output logic                               last_code
);

  hcb_pkg::dp_cmd_t    cmd;
  hcb_pkg::dp_status_t st;

  hcb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_weight(last_weight),
    .out_ready  (out_ready),
    .st         (st),
    .cmd        (cmd),
    .in_ready   (in_ready),
    .out_valid  (out_valid)
  );

  hcb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .weight     (weight),
    .st         (st),
    .code_bits  (code_bits),
    .code_length(code_length),
    .last_code  (last_code)
  );

endmodule

`default_nettype wire

// ----- hdl/hcb_ctrl.sv -----
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer for load, heap build, merge loop and code walk.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               last_weight,
  input  wire logic               out_ready,
  input  wire hcb_pkg::dp_status_t st,
  output hcb_pkg::dp_cmd_t        cmd,
  output logic                    in_ready,
  output logic                    out_valid
);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_HP_CHECK, S_HP_START, S_SD_LOAD, S_SD_TEST, S_SD_CMP,
    S_MG_CHECK, S_POP_RD, S_POP_TAKE, S_MG_WA, S_MG_WB, S_SU_TEST, S_SU_CMP,
    S_WK_INIT, S_WK_TEST, S_WK_STEP, S_WK_OUT
  } state_t;

  typedef enum logic [1:0] {
    CTX_HEAPIFY, CTX_POP1, CTX_POP2
  } ctx_t;

  state_t state, state_next, after_sift;
  ctx_t   ctx, ctx_next;

  always_comb begin
    unique case (ctx)
      CTX_HEAPIFY: after_sift = S_HP_CHECK;
      CTX_POP1:    after_sift = S_POP_RD;
      CTX_POP2:    after_sift = S_MG_WA;
      default:     after_sift = S_MG_WA;
    endcase
  end

  always_comb begin
    state_next = state;
    ctx_next   = ctx;
    cmd.op     = hcb_pkg::OP_NONE;
    cmd.wk     = hcb_pkg::WK_NONE;
    cmd.second = (ctx == CTX_POP2);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = hcb_pkg::OP_LOAD;
          if (last_weight) state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.op     = hcb_pkg::OP_INIT;
        ctx_next   = CTX_HEAPIFY;
        state_next = S_HP_CHECK;
      end
      S_HP_CHECK: begin
        state_next = st.idx_zero ? S_MG_CHECK : S_HP_START;
      end
      S_HP_START: begin
        cmd.op     = hcb_pkg::OP_HP_START;
        state_next = S_SD_LOAD;
      end
      S_SD_LOAD: begin
        cmd.op     = hcb_pkg::OP_SD_LOADCUR;
        state_next = S_SD_TEST;
      end
      S_SD_TEST: begin
        if (st.kid_gt_end) begin
          cmd.op     = hcb_pkg::OP_SD_FINAL;
          state_next = after_sift;
          if (ctx == CTX_POP1) ctx_next = CTX_POP2;
        end else begin
          cmd.op     = hcb_pkg::OP_SD_ISSUE;
          state_next = S_SD_CMP;
        end
      end
      S_SD_CMP: begin
        cmd.op = hcb_pkg::OP_SD_CMP;
        if (st.sd_move) begin
          state_next = S_SD_TEST;
        end else begin
          state_next = after_sift;
          if (ctx == CTX_POP1) ctx_next = CTX_POP2;
        end
      end
      S_MG_CHECK: begin
        if (st.fill_gt1) begin
          ctx_next   = CTX_POP1;
          state_next = S_POP_RD;
        end else begin
          state_next = S_WK_INIT;
        end
      end
      S_POP_RD: begin
        cmd.op     = hcb_pkg::OP_POP_READ;
        state_next = S_POP_TAKE;
      end
      S_POP_TAKE: begin
        cmd.op     = hcb_pkg::OP_POP_TAKE;
        state_next = S_SD_TEST;
      end
      S_MG_WA: begin
        cmd.op     = hcb_pkg::OP_PAR_A;
        state_next = S_MG_WB;
      end
      S_MG_WB: begin
        cmd.op     = hcb_pkg::OP_PAR_B;
        state_next = S_SU_TEST;
      end
      S_SU_TEST: begin
        if (st.at_is_one) begin
          cmd.op     = hcb_pkg::OP_SU_FINAL;
          state_next = S_MG_CHECK;
        end else begin
          cmd.op     = hcb_pkg::OP_SU_ISSUE;
          state_next = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        cmd.op     = hcb_pkg::OP_SU_CMP;
        state_next = st.su_move ? S_SU_TEST : S_MG_CHECK;
      end
      S_WK_INIT: begin
        cmd.op     = hcb_pkg::OP_WK_INIT;
        state_next = S_WK_TEST;
      end
      S_WK_TEST: begin
        if (st.walk_done) begin
          cmd.wk     = hcb_pkg::WK_EMIT;
          state_next = S_WK_OUT;
        end else begin
          state_next = S_WK_STEP;
        end
      end
      S_WK_STEP: begin
        cmd.wk     = hcb_pkg::WK_STEP;
        state_next = S_WK_TEST;
      end
      S_WK_OUT: begin
        if (out_ready) begin
          cmd.wk     = hcb_pkg::WK_NEXT;
          state_next = st.k_last ? S_IDLE : S_WK_TEST;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_WK_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctx   <= CTX_HEAPIFY;
    end else begin
      state <= state_next;
      ctx   <= ctx_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hcb_dp.sv -----
// ----------------------------------------------------------------------------
// hcb_dp
// Heap memory, parent memory, sift pointers and code walk registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire hcb_pkg::dp_cmd_t                 cmd,
  input  wire logic [hcb_pkg::WEIGHT_W-1:0]     weight,
  output hcb_pkg::dp_status_t                   st,
  output logic [hcb_pkg::CODE_W-1:0]            code_bits,
  output logic [hcb_pkg::LEN_W-1:0]             code_length,
  output logic                                  last_code
);

  logic [hcb_pkg::POS_W-1:0]  cnt, n_sym, fill, at, next_node, root, at_w;
  logic [hcb_pkg::ADDR_W-1:0] idx, k;
  logic [hcb_pkg::LEN_W-1:0]  len;
  logic [hcb_pkg::CODE_W-1:0] bits;
  hcb_pkg::heap_entry_t       cur, pa, pb, rd_a, rd_b;

  hcb_pkg::heap_entry_t heap_mem [hcb_pkg::MAX_SYMBOLS];
  logic [hcb_pkg::NODE_W:0] par_mem [hcb_pkg::NODE_DEPTH];
  logic [hcb_pkg::NODE_W:0] par_rd;

  logic [hcb_pkg::POS_W:0]    kid, fill_x;
  logic [hcb_pkg::POS_W-1:0]  up, cpos;
  logic                       take_b;
  hcb_pkg::heap_entry_t       child;

  logic [hcb_pkg::ADDR_W-1:0] addr_a, addr_b, waddr;
  logic                       we;
  hcb_pkg::heap_entry_t       wdata;
  logic                       par_we;
  logic [hcb_pkg::NODE_W-1:0] par_waddr;
  logic [hcb_pkg::NODE_W:0]   par_wdata;

  assign kid    = {at, 1'b0};
  assign fill_x = {1'b0, fill};
  assign up     = {1'b0, at[hcb_pkg::POS_W-1:1]};
  assign take_b = (kid < fill_x) && (rd_b.w < rd_a.w);
  assign child  = take_b ? rd_b : rd_a;
  assign cpos   = take_b ? (kid[hcb_pkg::POS_W-1:0] + 1'b1) : kid[hcb_pkg::POS_W-1:0];

  assign st.kid_gt_end = (kid > fill_x);
  assign st.sd_move    = (child.w < cur.w);
  assign st.at_is_one  = (at == 7'd1);
  assign st.su_move    = (cur.w < rd_a.w);
  assign st.idx_zero   = (idx == '0);
  assign st.fill_gt1   = (fill > 7'd1);
  assign st.walk_done  = (at_w == root) || (len == 6'd63);
  assign st.k_last     = ({1'b0, k} == (n_sym - 1'b1));

  // heap positions are 1-based, memory addresses 0-based
  always_comb begin
    addr_a    = '0;
    addr_b    = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = cur;
    par_we    = 1'b0;
    par_waddr = pa.node;
    par_wdata = {next_node, 1'b0};
    case (cmd.op)
      hcb_pkg::OP_LOAD: begin
        we    = (cnt < 7'(hcb_pkg::MAX_SYMBOLS));
        waddr = cnt[hcb_pkg::ADDR_W-1:0];
        wdata = '{w: hcb_pkg::SUM_W'(weight), node: cnt};
      end
      hcb_pkg::OP_HP_START: addr_a = idx - 1'b1;
      hcb_pkg::OP_SD_ISSUE: begin
        addr_a = kid[hcb_pkg::ADDR_W-1:0] - 1'b1;
        addr_b = kid[hcb_pkg::ADDR_W-1:0];
      end
      hcb_pkg::OP_SD_FINAL, hcb_pkg::OP_SU_FINAL: begin
        we    = 1'b1;
        waddr = 6'(at - 1'b1);
      end
      hcb_pkg::OP_SD_CMP: begin
        we    = 1'b1;
        waddr = 6'(at - 1'b1);
        wdata = st.sd_move ? child : cur;
      end
      hcb_pkg::OP_POP_READ: begin
        addr_a = '0;
        addr_b = 6'(fill - 1'b1);
      end
      hcb_pkg::OP_PAR_A: par_we = 1'b1;
      hcb_pkg::OP_PAR_B: begin
        par_we    = 1'b1;
        par_waddr = pb.node;
        par_wdata = {next_node, 1'b1};
      end
      hcb_pkg::OP_SU_ISSUE: addr_a = 6'(up - 1'b1);
      hcb_pkg::OP_SU_CMP: begin
        we    = 1'b1;
        waddr = 6'(at - 1'b1);
        wdata = st.su_move ? rd_a : cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) heap_mem[waddr] <= wdata;
    rd_a <= heap_mem[addr_a];
    rd_b <= heap_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_waddr] <= par_wdata;
    par_rd <= par_mem[at_w];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      fill <= '0;
    end else begin
      case (cmd.op)
        hcb_pkg::OP_LOAD: begin
          if (cnt < 7'(hcb_pkg::MAX_SYMBOLS)) cnt <= cnt + 1'b1;
        end
        hcb_pkg::OP_INIT: begin
          n_sym     <= cnt;
          fill      <= cnt;
          idx       <= cnt[hcb_pkg::POS_W-1:1];
          next_node <= cnt;
          root      <= '0;
        end
        hcb_pkg::OP_HP_START: begin
          at  <= {1'b0, idx};
          idx <= idx - 1'b1;
        end
        hcb_pkg::OP_SD_LOADCUR: cur <= rd_a;
        hcb_pkg::OP_SD_CMP: begin
          if (st.sd_move) at <= cpos;
        end
        hcb_pkg::OP_POP_TAKE: begin
          if (cmd.second) pb <= rd_a;
          else pa <= rd_a;
          cur  <= rd_b;
          fill <= fill - 1'b1;
          at   <= 7'd1;
        end
        hcb_pkg::OP_PAR_B: begin
          cur       <= '{w: pa.w + pb.w, node: next_node};
          fill      <= fill + 1'b1;
          at        <= fill + 1'b1;
          root      <= next_node;
          next_node <= next_node + 1'b1;
        end
        hcb_pkg::OP_SU_CMP: begin
          if (st.su_move) at <= up;
        end
        hcb_pkg::OP_WK_INIT: begin
          k    <= '0;
          at_w <= '0;
          len  <= '0;
          bits <= '0;
        end
        default: ;
      endcase
      case (cmd.wk)
        hcb_pkg::WK_STEP: begin
          bits <= bits | (hcb_pkg::CODE_W'(par_rd[0]) << len);
          len  <= len + 1'b1;
          at_w <= par_rd[hcb_pkg::NODE_W:1];
        end
        hcb_pkg::WK_EMIT: begin
          code_bits   <= bits;
          code_length <= len;
          last_code   <= st.k_last;
        end
        hcb_pkg::WK_NEXT: begin
          if (st.k_last) begin
            cnt  <= '0;
            fill <= '0;
          end
          k    <= k + 1'b1;
          at_w <= {1'b0, k} + 1'b1;
          len  <= '0;
          bits <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hcb_checker.sv -----
// ----------------------------------------------------------------------------
// hcb_checker
// Port-level checks of the huffman code builder.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         last_weight,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [hcb_pkg::CODE_W-1:0]   code_bits,
  input wire logic [hcb_pkg::LEN_W-1:0]    code_length
);

  // no new weights while codes are being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a code is pending");

  // a weight that is not last keeps the load open
  a_load_open: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last_weight) |=> in_ready)
    else $error("load stalled after a non-last weight");

  // bits above the code length stay clear
  a_code_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((code_bits >> code_length) == '0))
    else $error("code bits beyond code length");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(code_bits)))
    else $error("result dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .last_weight(last_weight),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .code_bits  (code_bits),
  .code_length(code_length)
);

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Huffman code builder check: random weight batches against a tree predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class code_board;
  logic [62:0] exp_bits[$];
  logic [5:0]  exp_len[$];
  logic        exp_last[$];
  logic [21:0] wgt[127];
  logic [6:0]  par[127];
  logic        side[127];
  logic [6:0]  heap[65];
  int          fill;
  int          count;
  int          errors;
  int          codes_seen;

  function void sift_down(int start, int stop);
    int at, kid;
    logic [6:0] t;
    at = start;
    kid = at * 2;
    while (kid <= stop) begin
      if (kid + 1 <= stop && wgt[heap[kid+1]] < wgt[heap[kid]]) kid++;
      if (wgt[heap[kid]] < wgt[heap[at]]) begin
        t = heap[at]; heap[at] = heap[kid]; heap[kid] = t;
        at = kid;
        kid = at * 2;
      end else begin
        break;
      end
    end
  endfunction

  function int pop_min();
    int top;
    top = int'(heap[1]);
    heap[1] = heap[fill];
    fill--;
    sift_down(1, fill);
    return top;
  endfunction

  // builds the tree for the closed batch and queues one code per weight
  function void build_codes();
    int n, nxt, a, b, at, up, root, len;
    logic [6:0] t;
    logic [62:0] bits;
    n = count;
    nxt = n;
    fill = n;
    for (int i = 1; i <= n; i++) heap[i] = 7'(i - 1);
    for (int i = n / 2; i >= 1; i--) sift_down(i, fill);
    while (fill > 1) begin
      a = pop_min();
      b = pop_min();
      wgt[nxt] = wgt[a] + wgt[b];
      par[a] = 7'(nxt); side[a] = 0;
      par[b] = 7'(nxt); side[b] = 1;
      fill++;
      heap[fill] = 7'(nxt);
      at = fill;
      up = at / 2;
      while (up >= 1 && wgt[heap[at]] < wgt[heap[up]]) begin
        t = heap[at]; heap[at] = heap[up]; heap[up] = t;
        at = up;
        up = at / 2;
      end
      nxt++;
    end
    root = int'(heap[1]);
    for (int k = 0; k < n; k++) begin
      bits = '0;
      len = 0;
      at = k;
      while (at != root && len < 63) begin
        bits[len] = side[at];
        len++;
        at = int'(par[at]);
      end
      exp_bits.push_back(bits);
      exp_len.push_back(len[5:0]);
      exp_last.push_back(k + 1 == n);
    end
    count = 0;
    fill = 0;
  endfunction

  function void note_weight(logic [15:0] w, logic last);
    if (count < 64) begin
      wgt[count] = {6'd0, w};
      count++;
    end
    if (last) build_codes();
  endfunction

  function void check_code(logic [62:0] bits, logic [5:0] len, logic last);
    codes_seen++;
    if (exp_bits.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected code beat bits=%h len=%0d", bits, len);
      return;
    end
    if (bits !== exp_bits[0] || len !== exp_len[0] || last !== exp_last[0]) begin
      errors++;
      if (errors <= 10)
        $display("code mismatch: exp bits=%h len=%0d last=%b, got bits=%h len=%0d last=%b",
                 exp_bits[0], exp_len[0], exp_last[0], bits, len, last);
    end
    void'(exp_bits.pop_front());
    void'(exp_len.pop_front());
    void'(exp_last.pop_front());
  endfunction
endclass

module tb;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [hcb_pkg::WEIGHT_W-1:0] weight = '0;
  logic last_weight = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [hcb_pkg::CODE_W-1:0] code_bits;
  logic [hcb_pkg::LEN_W-1:0] code_length;
  logic last_code;

  code_board board;
  int  idle_pct = 34;
  int  beats_sent;
  int  batches;
  bit  quiet_stretch;

  huffman_code_builder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .weight(weight), .last_weight(last_weight),
    .out_valid(out_valid), .out_ready(out_ready),
    .code_bits(code_bits), .code_length(code_length), .last_code(last_code)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // result side: random stalls, check on each accepted beat
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_code(code_bits, code_length, last_code);
      out_ready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= idle_pct);
    end
  end

  // valid stays high from one beat to the next unless an idle cycle comes
  task send_beat(input logic [15:0] w, input logic last);
    while (!quiet_stretch && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    weight <= w;
    last_weight <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_weight(w, last);
    beats_sent++;
  endtask

  // mode 0 random, 1 all equal, 2 extremes, 3 tiny range
  task send_batch(input int n, input int mode);
    logic [15:0] w;
    logic [15:0] eq;
    eq = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: w = 16'($urandom);
        1: w = eq;
        2: w = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
        default: w = 16'($urandom_range(3));
      endcase
      send_beat(w, i == n - 1);
    end
    batches++;
  endtask

  task drain();
    in_valid <= 0;
    while (board.exp_bits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int n;
    board = new();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: single weight, pair, equal weights, extremes, full and overflow
    send_batch(1, 0);
    send_beat(16'hFFFF, 0); send_beat(16'h0000, 1); batches++;
    send_batch(4, 1);
    send_batch(5, 2);
    drain();
    send_batch(64, 0);
    for (int i = 0; i < 67; i++) send_beat(16'hFFFF - i[15:0], i == 66);
    batches++;
    // pause until all codes are back
    drain();
    quiet_stretch = 1;
    send_batch(40, 0);
    send_batch(8, 0);
    send_batch(3, 3);
    quiet_stretch = 0;
    while (beats_sent < 400) begin
      n = ($urandom_range(9) == 0) ? int'($urandom_range(64, 40))
                                   : int'($urandom_range(12, 1));
      send_batch(n, int'($urandom_range(3)));
    end
    drain();
    $display("ran %0d batches, %0d weight beats, %0d code beats checked",
             batches, beats_sent, board.codes_seen);
    if (board.errors == 0 && board.exp_bits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- files.f -----
hdl/hcb_pkg.sv
hdl/hcb_ctrl.sv
hdl/hcb_dp.sv
hdl/huffman_code_builder.sv
hdl/hcb_checker.sv
test/tb.sv
